[src/bevt_pkg.sv]
// ----------------------------------------------------------------------------
// bevt_pkg
// Shared widths, codes, micro-program and fixed-point helpers for the bond
// energy and virial tally.
// ----------------------------------------------------------------------------
package bevt_pkg;

  localparam int ATOM_SLOTS    = 1024;
  localparam int MAX_ANG_TERMS = 6;
  localparam int AW            = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
  localparam int IDX_W         = 10;
  localparam int LAC_W         = 11;
  localparam int IN_W          = 32;
  localparam int ACC_W         = 48;
  localparam int FRAC_W        = 16;
  localparam int TENS_N        = 6;
  localparam int ENTRY_W       = ACC_W * (TENS_N + 1);
  localparam int TERM_W        = (MAX_ANG_TERMS > 0) ? $clog2(MAX_ANG_TERMS + 1) : 1;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_DATA_W     = 184;
  localparam int OUT_DATA_W    = 352;
  localparam int UOP_W         = 5;
  localparam int OPND_N        = 19;

  localparam logic [UOP_W-1:0] HDR_FIRST = 5'd0;
  localparam logic [UOP_W-1:0] HDR_LAST  = 5'd11;
  localparam logic [UOP_W-1:0] ANG_FIRST = 5'd12;
  localparam logic [UOP_W-1:0] ANG_LAST  = 5'd29;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEWTON      = 3'd0,
    CFG_LOCAL_COUNT = 3'd1,
    CFG_E_GLOBAL    = 3'd2,
    CFG_E_ATOM      = 3'd3,
    CFG_V_GLOBAL    = 3'd4,
    CFG_V_ATOM      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OPC_HEADER  = 2'd0,
    OPC_ANGULAR = 2'd1,
    OPC_READ    = 2'd2,
    OPC_NONE    = 2'd3
  } opcode_e;

  typedef enum logic {
    KIND_GLOBAL = 1'b0,
    KIND_ATOM   = 1'b1
  } kind_e;

  // Operand sources of the shared multiplier
  typedef enum logic [UOP_W-1:0] {
    OP_UX, OP_UY, OP_UZ, OP_S, OP_RX, OP_RY, OP_RZ,
    OP_P0, OP_P1, OP_P2, OP_P3, OP_P4, OP_P5,
    OP_G0, OP_G1, OP_G2, OP_D0, OP_D1, OP_D2
  } opnd_e;

  // P: r_a*r_b products, T: pending tensor, G: g (also seeds d), D: d
  typedef enum logic [1:0] {
    GRP_P, GRP_T, GRP_G, GRP_D
  } grp_e;

  typedef enum logic [1:0] {
    MODE_SET, MODE_ADD, MODE_SUB
  } mode_e;

  typedef struct packed {
    opnd_e      a;
    opnd_e      b;
    grp_e       grp;
    logic [2:0] idx;
    mode_e      mode;
  } uop_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] prod;
  } mul_rsp_t;

  function automatic uop_t mk(input opnd_e a, input opnd_e b, input grp_e g,
                              input logic [2:0] k, input mode_e m);
    uop_t u;
    u.a    = a;
    u.b    = b;
    u.grp  = g;
    u.idx  = k;
    u.mode = m;
    return u;
  endfunction

  function automatic uop_t uop_at(input logic [UOP_W-1:0] pc);
    uop_t u;
    u = mk(OP_UX, OP_UX, GRP_P, 3'd0, MODE_SET);
    case (pc)
      // header: r_a*r_b, then times f
      5'd0:  u = mk(OP_UX, OP_UX, GRP_P, 3'd0, MODE_SET);
      5'd1:  u = mk(OP_UY, OP_UY, GRP_P, 3'd1, MODE_SET);
      5'd2:  u = mk(OP_UZ, OP_UZ, GRP_P, 3'd2, MODE_SET);
      5'd3:  u = mk(OP_UX, OP_UY, GRP_P, 3'd3, MODE_SET);
      5'd4:  u = mk(OP_UX, OP_UZ, GRP_P, 3'd4, MODE_SET);
      5'd5:  u = mk(OP_UY, OP_UZ, GRP_P, 3'd5, MODE_SET);
      5'd6:  u = mk(OP_P0, OP_S,  GRP_T, 3'd0, MODE_SET);
      5'd7:  u = mk(OP_P1, OP_S,  GRP_T, 3'd1, MODE_SET);
      5'd8:  u = mk(OP_P2, OP_S,  GRP_T, 3'd2, MODE_SET);
      5'd9:  u = mk(OP_P3, OP_S,  GRP_T, 3'd3, MODE_SET);
      5'd10: u = mk(OP_P4, OP_S,  GRP_T, 3'd4, MODE_SET);
      5'd11: u = mk(OP_P5, OP_S,  GRP_T, 3'd5, MODE_SET);
      // angular: g = c*u
      5'd12: u = mk(OP_S,  OP_UX, GRP_G, 3'd0, MODE_SET);
      5'd13: u = mk(OP_S,  OP_UY, GRP_G, 3'd1, MODE_SET);
      5'd14: u = mk(OP_S,  OP_UZ, GRP_G, 3'd2, MODE_SET);
      // d = g - (r r) g
      5'd15: u = mk(OP_G0, OP_P0, GRP_D, 3'd0, MODE_SUB);
      5'd16: u = mk(OP_G1, OP_P3, GRP_D, 3'd0, MODE_SUB);
      5'd17: u = mk(OP_G2, OP_P4, GRP_D, 3'd0, MODE_SUB);
      5'd18: u = mk(OP_G0, OP_P3, GRP_D, 3'd1, MODE_SUB);
      5'd19: u = mk(OP_G1, OP_P1, GRP_D, 3'd1, MODE_SUB);
      5'd20: u = mk(OP_G2, OP_P5, GRP_D, 3'd1, MODE_SUB);
      5'd21: u = mk(OP_G0, OP_P4, GRP_D, 3'd2, MODE_SUB);
      5'd22: u = mk(OP_G1, OP_P5, GRP_D, 3'd2, MODE_SUB);
      5'd23: u = mk(OP_G2, OP_P2, GRP_D, 3'd2, MODE_SUB);
      // tensor += r_a*d_b
      5'd24: u = mk(OP_RX, OP_D0, GRP_T, 3'd0, MODE_ADD);
      5'd25: u = mk(OP_RY, OP_D1, GRP_T, 3'd1, MODE_ADD);
      5'd26: u = mk(OP_RZ, OP_D2, GRP_T, 3'd2, MODE_ADD);
      5'd27: u = mk(OP_RX, OP_D1, GRP_T, 3'd3, MODE_ADD);
      5'd28: u = mk(OP_RX, OP_D2, GRP_T, 3'd4, MODE_ADD);
      5'd29: u = mk(OP_RY, OP_D2, GRP_T, 3'd5, MODE_ADD);
      default: u = mk(OP_UX, OP_UX, GRP_P, 3'd0, MODE_SET);
    endcase
    return u;
  endfunction

  function automatic logic [ACC_W-1:0] sext48(input logic [IN_W-1:0] v);
    return {{(ACC_W - IN_W){v[IN_W-1]}}, v};
  endfunction

  // arithmetic shift right by one, floor
  function automatic logic [ACC_W-1:0] half48(input logic [ACC_W-1:0] v);
    return {v[ACC_W-1], v[ACC_W-1:1]};
  endfunction

  function automatic logic atom_in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < ATOM_SLOTS;
  endfunction

  function automatic logic [AW-1:0] atom_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+AW-1:0] w;
    w = (IDX_W + AW)'(idx);
    return w[AW-1:0];
  endfunction

endpackage

[src/bond_energy_virial_tally.sv]
// ----------------------------------------------------------------------------
// bond_energy_virial_tally
// Tallies bond energy and virial into global and per-atom accumulators.
// Header: 12 multiplier steps. Angular item: 18 steps. Commit reads and writes
// the per-atom entry of i, then that of j, and then reports the global totals.
// One item at a time; the shared multiplier and the per-atom RAM port set it.
// After reset a clearing pass zeroes the per-atom RAM; no item is taken
// meanwhile. Global and pending state clear at reset.
// ----------------------------------------------------------------------------
module bond_energy_virial_tally (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bevt_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bevt_pkg::LAC_W-1:0]           cfg_wdata_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // atom_first, atom_second, bond_energy, scalar_force, vec_x, vec_y, vec_z
  input  logic [bevt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // opcode
  input  logic [1:0]                           s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // atom_index, energy_total, tensor_xx, yy, zz, xy, xz, yz
  output logic [bevt_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // report_kind
  output logic                                 m_axis_tuser
);

  localparam int AW    = bevt_pkg::AW;
  localparam int ACC_W = bevt_pkg::ACC_W;
  localparam int IN_W  = bevt_pkg::IN_W;
  localparam int IDX_W = bevt_pkg::IDX_W;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_GLB   = 4'd3;
  localparam logic [3:0] ST_WRI   = 4'd4;
  localparam logic [3:0] ST_RDJ   = 4'd5;
  localparam logic [3:0] ST_WRJ   = 4'd6;
  localparam logic [3:0] ST_OUTG  = 4'd7;
  localparam logic [3:0] ST_OUTA  = 4'd8;

  // configuration
  logic                    newton_q, e_glb_en_q, e_atom_en_q, v_glb_en_q, v_atom_en_q;
  logic [bevt_pkg::LAC_W-1:0] lac_q;

  // control
  logic [3:0]                  state_q;
  logic [AW-1:0]               clr_q;
  logic                        pend_q;
  logic [bevt_pkg::TERM_W-1:0] term_q;
  logic [bevt_pkg::UOP_W-1:0]  uop_q, uop_end_q;
  logic                        issue_q;
  logic                        out_valid_q;

  // payload
  logic [IDX_W-1:0]   i_q, j_q, rdx_q;
  logic [IN_W-1:0]    e_q, s_q;
  logic [IN_W-1:0]    r_q [3];
  logic [IN_W-1:0]    u_q [3];
  logic               last_q, rd_oob_q;
  logic [ACC_W-1:0]   p_q [6];
  logic [ACC_W-1:0]   t_q [6];
  logic [ACC_W-1:0]   g_q [3];
  logic [ACC_W-1:0]   d_q [3];
  logic [ACC_W-1:0]   tot_e_q;
  logic [ACC_W-1:0]   tot_t_q [6];
  logic               out_kind_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [ACC_W-1:0]   out_e_q;
  logic [ACC_W-1:0]   out_t_q [6];

  // input fields
  bevt_pkg::opcode_e in_opc;
  logic [IDX_W-1:0]  in_a1, in_a2;
  logic [IN_W-1:0]   in_e, in_s, in_x, in_y, in_z;
  logic              in_acc, out_free;

  assign in_opc = bevt_pkg::opcode_e'(s_axis_tuser);
  assign in_a1  = s_axis_tdata[9:0];
  assign in_a2  = s_axis_tdata[19:10];
  assign in_e   = s_axis_tdata[51:20];
  assign in_s   = s_axis_tdata[83:52];
  assign in_x   = s_axis_tdata[115:84];
  assign in_y   = s_axis_tdata[147:116];
  assign in_z   = s_axis_tdata[179:148];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // ---------------- multiplier step ----------------
  bevt_pkg::uop_t                       cur;
  logic [bevt_pkg::OPND_N-1:0][ACC_W-1:0] opnd_v;
  bevt_pkg::mul_req_t                   mreq;
  bevt_pkg::mul_rsp_t                   mrsp;
  logic [ACC_W-1:0]                     wb_cur, wb_val;
  logic                                 wb_en;

  assign cur = bevt_pkg::uop_at(uop_q);

  always_comb begin
    opnd_v                   = '0;
    opnd_v[bevt_pkg::OP_UX]  = bevt_pkg::sext48(u_q[0]);
    opnd_v[bevt_pkg::OP_UY]  = bevt_pkg::sext48(u_q[1]);
    opnd_v[bevt_pkg::OP_UZ]  = bevt_pkg::sext48(u_q[2]);
    opnd_v[bevt_pkg::OP_S]   = bevt_pkg::sext48(s_q);
    opnd_v[bevt_pkg::OP_RX]  = bevt_pkg::sext48(r_q[0]);
    opnd_v[bevt_pkg::OP_RY]  = bevt_pkg::sext48(r_q[1]);
    opnd_v[bevt_pkg::OP_RZ]  = bevt_pkg::sext48(r_q[2]);
    opnd_v[bevt_pkg::OP_P0]  = p_q[0];
    opnd_v[bevt_pkg::OP_P1]  = p_q[1];
    opnd_v[bevt_pkg::OP_P2]  = p_q[2];
    opnd_v[bevt_pkg::OP_P3]  = p_q[3];
    opnd_v[bevt_pkg::OP_P4]  = p_q[4];
    opnd_v[bevt_pkg::OP_P5]  = p_q[5];
    opnd_v[bevt_pkg::OP_G0]  = g_q[0];
    opnd_v[bevt_pkg::OP_G1]  = g_q[1];
    opnd_v[bevt_pkg::OP_G2]  = g_q[2];
    opnd_v[bevt_pkg::OP_D0]  = d_q[0];
    opnd_v[bevt_pkg::OP_D1]  = d_q[1];
    opnd_v[bevt_pkg::OP_D2]  = d_q[2];
  end

  assign mreq.start = (state_q == ST_MUL) && issue_q;
  assign mreq.a     = opnd_v[cur.a];
  assign mreq.b     = opnd_v[cur.b];

  bevt_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign wb_en = (state_q == ST_MUL) && mrsp.done;

  always_comb begin
    case (cur.grp)
      bevt_pkg::GRP_T: wb_cur = t_q[cur.idx];
      bevt_pkg::GRP_D: wb_cur = d_q[cur.idx[1:0]];
      default:         wb_cur = '0;
    endcase
    case (cur.mode)
      bevt_pkg::MODE_ADD: wb_val = wb_cur + mrsp.prod;
      bevt_pkg::MODE_SUB: wb_val = wb_cur - mrsp.prod;
      default:            wb_val = mrsp.prod;
    endcase
  end

  // ---------------- commit arithmetic ----------------
  logic [ACC_W-1:0]          e48, eh, e_glb;
  logic [ACC_W-1:0]          vh [6];
  logic [ACC_W-1:0]          v_glb [6];
  logic                      iloc, jloc, ia, ja;
  logic [bevt_pkg::ENTRY_W-1:0] ram_rdata, ram_wdata, upd_entry;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;

  assign e48  = bevt_pkg::sext48(e_q);
  assign eh   = bevt_pkg::half48(e48);
  assign iloc = {1'b0, i_q} < lac_q;
  assign jloc = {1'b0, j_q} < lac_q;
  assign ia   = (newton_q || iloc) && bevt_pkg::atom_in_range(i_q);
  assign ja   = (newton_q || jloc) && bevt_pkg::atom_in_range(j_q);
  assign e_glb = newton_q ? e48 : ((iloc ? eh : '0) + (jloc ? eh : '0));

  always_comb begin
    upd_entry[ACC_W-1:0] = ram_rdata[ACC_W-1:0] + (e_atom_en_q ? eh : '0);
    for (int k = 0; k < bevt_pkg::TENS_N; k++) begin
      vh[k]    = bevt_pkg::half48(t_q[k]);
      v_glb[k] = newton_q ? t_q[k] : ((iloc ? vh[k] : '0) + (jloc ? vh[k] : '0));
      upd_entry[ACC_W*(k+1) +: ACC_W] = ram_rdata[ACC_W*(k+1) +: ACC_W]
                                        + (v_atom_en_q ? vh[k] : '0);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bevt_pkg::atom_addr(i_q);
    ram_wdata = upd_entry;
    ram_re    = 1'b0;
    ram_raddr = bevt_pkg::atom_addr(i_q);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_re    = in_acc && (in_opc == bevt_pkg::OPC_READ);
        ram_raddr = bevt_pkg::atom_addr(in_a1);
      end
      ST_GLB: ram_re = 1'b1;
      ST_WRI: ram_we = ia;
      ST_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = bevt_pkg::atom_addr(j_q);
      end
      ST_WRJ: begin
        ram_we    = ja;
        ram_waddr = bevt_pkg::atom_addr(j_q);
      end
      default: ;
    endcase
  end

  bevt_ram #(
    .WIDTH (bevt_pkg::ENTRY_W),
    .DEPTH (bevt_pkg::ATOM_SLOTS)
  ) u_atom_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newton_q    <= 1'b0;
      lac_q       <= '0;
      e_glb_en_q  <= 1'b0;
      e_atom_en_q <= 1'b0;
      v_glb_en_q  <= 1'b0;
      v_atom_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (bevt_pkg::cfg_idx_e'(cfg_idx_i))
        bevt_pkg::CFG_NEWTON:      newton_q    <= cfg_wdata_i[0];
        bevt_pkg::CFG_LOCAL_COUNT: lac_q       <= cfg_wdata_i;
        bevt_pkg::CFG_E_GLOBAL:    e_glb_en_q  <= cfg_wdata_i[0];
        bevt_pkg::CFG_E_ATOM:      e_atom_en_q <= cfg_wdata_i[0];
        bevt_pkg::CFG_V_GLOBAL:    v_glb_en_q  <= cfg_wdata_i[0];
        bevt_pkg::CFG_V_ATOM:      v_atom_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      term_q      <= '0;
      uop_q       <= '0;
      uop_end_q   <= '0;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      tot_e_q     <= '0;
      for (int k = 0; k < bevt_pkg::TENS_N; k++) begin
        tot_t_q[k] <= '0;
      end
    end else begin
      // the output states load a new transaction themselves
      if (out_valid_q && m_axis_tready && (state_q != ST_OUTG) && (state_q != ST_OUTA)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(bevt_pkg::ATOM_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            case (in_opc)
              bevt_pkg::OPC_HEADER: begin
                pend_q    <= 1'b1;
                term_q    <= '0;
                uop_q     <= bevt_pkg::HDR_FIRST;
                uop_end_q <= bevt_pkg::HDR_LAST;
                issue_q   <= 1'b1;
                state_q   <= ST_MUL;
              end
              bevt_pkg::OPC_ANGULAR: begin
                if (pend_q) begin
                  if (int'(term_q) < bevt_pkg::MAX_ANG_TERMS) begin
                    term_q    <= term_q + 1'b1;
                    uop_q     <= bevt_pkg::ANG_FIRST;
                    uop_end_q <= bevt_pkg::ANG_LAST;
                    issue_q   <= 1'b1;
                    state_q   <= ST_MUL;
                  end else if (s_axis_tlast) begin
                    state_q <= ST_GLB;
                  end
                end
              end
              bevt_pkg::OPC_READ: state_q <= ST_OUTA;
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          issue_q <= 1'b0;
          if (mrsp.done) begin
            if (uop_q == uop_end_q) begin
              state_q <= last_q ? ST_GLB : ST_IDLE;
            end else begin
              uop_q   <= uop_q + 1'b1;
              issue_q <= 1'b1;
            end
          end
        end
        ST_GLB: begin
          if (e_glb_en_q) begin
            tot_e_q <= tot_e_q + e_glb;
          end
          if (v_glb_en_q) begin
            for (int k = 0; k < bevt_pkg::TENS_N; k++) begin
              tot_t_q[k] <= tot_t_q[k] + v_glb[k];
            end
          end
          pend_q  <= 1'b0;
          term_q  <= '0;
          state_q <= ST_WRI;
        end
        ST_WRI: state_q <= ST_RDJ;
        ST_RDJ: state_q <= ST_WRJ;
        ST_WRJ: state_q <= ST_OUTG;
        ST_OUTG, ST_OUTA: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q      <= in_s;
      u_q[0]   <= in_x;
      u_q[1]   <= in_y;
      u_q[2]   <= in_z;
      last_q   <= s_axis_tlast;
      rdx_q    <= in_a1;
      rd_oob_q <= !bevt_pkg::atom_in_range(in_a1);
      if (in_opc == bevt_pkg::OPC_HEADER) begin
        i_q    <= in_a1;
        j_q    <= in_a2;
        e_q    <= in_e;
        r_q[0] <= in_x;
        r_q[1] <= in_y;
        r_q[2] <= in_z;
      end
    end
    if (wb_en) begin
      case (cur.grp)
        bevt_pkg::GRP_P: p_q[cur.idx] <= wb_val;
        bevt_pkg::GRP_T: t_q[cur.idx] <= wb_val;
        bevt_pkg::GRP_G: begin
          g_q[cur.idx[1:0]] <= wb_val;
          d_q[cur.idx[1:0]] <= wb_val;
        end
        bevt_pkg::GRP_D: d_q[cur.idx[1:0]] <= wb_val;
        default: ;
      endcase
    end
    if (out_free) begin
      if (state_q == ST_OUTG) begin
        out_kind_q <= bevt_pkg::KIND_GLOBAL;
        out_idx_q  <= '0;
        out_e_q    <= tot_e_q;
        for (int k = 0; k < bevt_pkg::TENS_N; k++) begin
          out_t_q[k] <= tot_t_q[k];
        end
      end else if (state_q == ST_OUTA) begin
        out_kind_q <= bevt_pkg::KIND_ATOM;
        out_idx_q  <= rdx_q;
        out_e_q    <= rd_oob_q ? '0 : ram_rdata[ACC_W-1:0];
        for (int k = 0; k < bevt_pkg::TENS_N; k++) begin
          out_t_q[k] <= rd_oob_q ? '0 : ram_rdata[ACC_W*(k+1) +: ACC_W];
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {6'd0, out_t_q[5], out_t_q[4], out_t_q[3], out_t_q[2],
                          out_t_q[1], out_t_q[0], out_e_q, out_idx_q};

endmodule

[src/bevt_ram.sv]
// ----------------------------------------------------------------------------
// bevt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bevt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bevt_mul.sv]
// ----------------------------------------------------------------------------
// bevt_mul
// Q32.16 multiplier: 48x48 product over one 32x32 multiplier, result floor
// shifted by the fraction width. Done rises after the low, cross and sum phases.
// ----------------------------------------------------------------------------
module bevt_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bevt_pkg::mul_req_t req_i,
  output bevt_pkg::mul_rsp_t rsp_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LL   = 3'd1;
  localparam logic [2:0] PH_HL   = 3'd2;
  localparam logic [2:0] PH_LH   = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [63:0] a_q, b_q;
  logic [63:0] prod_q, acc_q;
  logic [31:0] mx, my;
  logic [63:0] mp;

  always_comb begin
    case (phase_q)
      PH_HL: begin
        mx = a_q[63:32];
        my = b_q[31:0];
      end
      PH_LH: begin
        mx = a_q[31:0];
        my = b_q[63:32];
      end
      default: begin
        mx = a_q[31:0];
        my = b_q[31:0];
      end
    endcase
    mp = 64'(mx) * 64'(my);
  end

  always_comb begin
    case (phase_q)
      PH_LL, PH_HL, PH_LH, PH_SUM: phase_d = phase_q + 3'd1;
      default:                     phase_d = req_i.start ? PH_LL : PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // cross terms only matter modulo 2^32; the high-high term drops out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= {{16{req_i.a[bevt_pkg::ACC_W-1]}}, req_i.a};
      b_q <= {{16{req_i.b[bevt_pkg::ACC_W-1]}}, req_i.b};
    end
    prod_q <= mp;
    case (phase_q)
      PH_HL:         acc_q <= prod_q;
      PH_LH, PH_SUM: acc_q <= acc_q + {prod_q[31:0], 32'd0};
      default:       acc_q <= acc_q;
    endcase
  end

  assign rsp_o.done = (phase_q == PH_DONE);
  assign rsp_o.prod = acc_q[bevt_pkg::FRAC_W +: bevt_pkg::ACC_W];

endmodule
